// ----- sv/chfs_pkg.sv -----
package chfs_pkg;

   // offset counters and the header end offset
   localparam int OFFSET_BITS = 16;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   // result fields
   localparam int OUT_BITS = 16;
   localparam logic [OUT_BITS-1:0] OUT_MAX = '1;
   localparam int KEY_BITS = 3;

   // length words on the wire
   localparam int LEN_BITS = 32;

   // known keys
   localparam int NUM_KEYS = 5;
   localparam int KEY_CHARS = 11;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = RSP_PTR_BITS + 1;

   typedef enum logic [1:0] {
      PH_PREAMBLE,
      PH_LENGTH,
      PH_BODY,
      PH_DONE
   } phase_type;

   typedef enum logic [KEY_BITS-1:0] {
      KEY_CALLERID,
      KEY_MD5SUM,
      KEY_NO_DELAY,
      KEY_TOPIC,
      KEY_TYPE
   } key_type;

   localparam logic EV_FIELD = 1'b0;
   localparam logic EV_END = 1'b1;

   localparam logic [8*KEY_CHARS-1:0] KEY_STR [NUM_KEYS] = '{
      "callerid=", "md5sum=", "tcp_nodely=", "topic=", "type="
   };
   localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{4'd9, 4'd7, 4'd11, 4'd6, 4'd5};

   typedef struct packed {
      logic                 event_kind;
      logic [KEY_BITS-1:0]  field_key;
      logic [OUT_BITS-1:0]  value_offset;
      logic [OUT_BITS-1:0]  value_length;
      logic                 last_of_run;
   } rsp_type;

   typedef struct packed {
      logic    field_valid;
      logic    end_valid;
      rsp_type field_rsp;
      rsp_type end_rsp;
   } scan_out_type;

   // character of a key at a position, zero past its end
   function automatic logic [7:0] key_char(input int k, input logic [3:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      if (pos < KEY_LEN[k]) begin
         ch = KEY_STR[k][8*(int'(KEY_LEN[k]) - 1 - int'(pos)) +: 8];
      end
      return ch;
   endfunction

   // clamp a length word to the offset range
   function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [LEN_BITS-1:0] v);
      logic [OFFSET_BITS-1:0] r;
      if (v > LEN_BITS'(OFFSET_MAX)) begin
         r = OFFSET_MAX;
      end else begin
         r = OFFSET_BITS'(v);
      end
      return r;
   endfunction

   // clamp an offset to the result field range
   function automatic logic [OUT_BITS-1:0] sat_out(input logic [OFFSET_BITS-1:0] v);
      logic [OUT_BITS-1:0] r;
      if (LEN_BITS'(v) > LEN_BITS'(OUT_MAX)) begin
         r = OUT_MAX;
      end else begin
         r = OUT_BITS'(v);
      end
      return r;
   endfunction

endpackage

// ----- sv/chfs_req_if.sv -----
interface chfs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_of_packet;

   modport source (output valid, output data_byte, output first_of_packet, input ready);
   modport sink (input valid, input data_byte, input first_of_packet, output ready);
endinterface

// ----- sv/chfs_rsp_if.sv -----
interface chfs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           event_kind;
   logic [chfs_pkg::KEY_BITS-1:0]  field_key;
   logic [chfs_pkg::OUT_BITS-1:0]  value_offset;
   logic [chfs_pkg::OUT_BITS-1:0]  value_length;
   logic                           last_of_run;

   modport source (output valid, output event_kind, output field_key, output value_offset,
                   output value_length, output last_of_run, input ready);
   modport sink (input valid, input event_kind, input field_key, input value_offset,
                 input value_length, input last_of_run, output ready);
endinterface

// ----- sv/chfs_scan_core.sv -----
module chfs_scan_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic                   first_of_packet,
   output chfs_pkg::scan_out_type scan_out
);

   chfs_pkg::phase_type phase_ff, phase_in;
   logic [chfs_pkg::OFFSET_BITS-1:0] byte_off_ff, byte_off_in;
   logic [chfs_pkg::OFFSET_BITS-1:0] hdr_end_ff, hdr_end_in;
   logic [chfs_pkg::LEN_BITS-1:0]    len_asm_ff, len_asm_in;
   logic [1:0]                       len_idx_ff, len_idx_in;
   logic [chfs_pkg::OFFSET_BITS-1:0] entry_len_ff, entry_len_in;
   logic [chfs_pkg::OFFSET_BITS-1:0] entry_pos_ff, entry_pos_in;
   logic [chfs_pkg::NUM_KEYS-1:0]    alive_ff, alive_in;

   // view of the state once a restart mark is applied
   chfs_pkg::phase_type eff_phase;
   logic [chfs_pkg::OFFSET_BITS-1:0] eff_off;
   logic [chfs_pkg::LEN_BITS-1:0]    eff_asm;
   logic [1:0]                       eff_idx;

   logic                             active;
   logic [chfs_pkg::OFFSET_BITS-1:0] next_off;
   logic                             pre_take, pre_done;
   logic [chfs_pkg::LEN_BITS-1:0]    pre_asm, len_asm;
   logic                             len_done;
   logic [chfs_pkg::OFFSET_BITS-1:0] len_value;
   logic [chfs_pkg::OFFSET_BITS-1:0] pos_next;
   logic                             body_done;
   logic [chfs_pkg::NUM_KEYS-1:0]    keep;
   logic                             hit_any;
   logic [chfs_pkg::KEY_BITS-1:0]    hit_key;
   logic [chfs_pkg::OFFSET_BITS-1:0] hit_len;
   logic                             boundary;
   logic [chfs_pkg::OFFSET_BITS-1:0] hdr_end_new;
   logic                             end_hit;

   always_comb begin
      eff_phase = first_of_packet ? chfs_pkg::PH_PREAMBLE : phase_ff;
      eff_off   = first_of_packet ? '0 : byte_off_ff;
      eff_asm   = first_of_packet ? '0 : len_asm_ff;
      eff_idx   = first_of_packet ? '0 : len_idx_ff;
   end

   assign active   = step && (eff_phase != chfs_pkg::PH_DONE);
   assign next_off = (eff_off == chfs_pkg::OFFSET_MAX) ? eff_off : eff_off + 1'b1;

   // preamble: bytes 4..7 form the header end offset
   assign pre_take = (eff_off >= chfs_pkg::OFFSET_BITS'(4)) &&
                     (eff_off < chfs_pkg::OFFSET_BITS'(8));
   assign pre_done = eff_off >= chfs_pkg::OFFSET_BITS'(7);
   assign pre_asm  = pre_take ?
                     (eff_asm | (chfs_pkg::LEN_BITS'(data_byte) << {eff_off[1:0], 3'b000})) :
                     eff_asm;

   // entry length word, little endian
   assign len_asm   = eff_asm | (chfs_pkg::LEN_BITS'(data_byte) << {eff_idx, 3'b000});
   assign len_done  = eff_idx == 2'd3;
   assign len_value = chfs_pkg::sat_off(len_asm);

   // entry body
   assign pos_next  = entry_pos_ff + 1'b1;
   assign body_done = pos_next >= entry_len_ff;

   always_comb begin
      hit_any = 1'b0;
      hit_key = chfs_pkg::KEY_CALLERID;
      hit_len = '0;
      for (int k = 0; k < chfs_pkg::NUM_KEYS; k++) begin
         keep[k] = alive_ff[k] &&
                   (entry_pos_ff < chfs_pkg::OFFSET_BITS'(chfs_pkg::KEY_LEN[k])) &&
                   (chfs_pkg::key_char(k, entry_pos_ff[3:0]) == data_byte);
         if (keep[k] &&
             (entry_pos_ff == chfs_pkg::OFFSET_BITS'(chfs_pkg::KEY_LEN[k] - 4'd1))) begin
            hit_any = 1'b1;
            hit_key = chfs_pkg::KEY_BITS'(k);
            hit_len = entry_len_ff - chfs_pkg::OFFSET_BITS'(chfs_pkg::KEY_LEN[k]);
         end
      end
   end

   always_comb begin
      boundary = 1'b0;
      unique case (eff_phase)
         chfs_pkg::PH_PREAMBLE: boundary = pre_done;
         chfs_pkg::PH_LENGTH:   boundary = len_done;
         chfs_pkg::PH_BODY:     boundary = body_done;
         chfs_pkg::PH_DONE:     boundary = 1'b0;
         default:               boundary = 1'b0;
      endcase
   end

   assign hdr_end_new = ((eff_phase == chfs_pkg::PH_PREAMBLE) && pre_done) ?
                        chfs_pkg::sat_off(pre_asm) : hdr_end_ff;
   assign end_hit     = active && boundary && (next_off >= hdr_end_new);

   // phase sequencing
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         phase_in = eff_phase;
         unique case (eff_phase)
            chfs_pkg::PH_PREAMBLE: if (pre_done) phase_in = chfs_pkg::PH_LENGTH;
            chfs_pkg::PH_LENGTH:   if (len_done && (len_value != '0)) phase_in = chfs_pkg::PH_BODY;
            chfs_pkg::PH_BODY:     if (body_done) phase_in = chfs_pkg::PH_LENGTH;
            chfs_pkg::PH_DONE:     phase_in = chfs_pkg::PH_DONE;
            default:               phase_in = eff_phase;
         endcase
         if (end_hit) begin
            phase_in = chfs_pkg::PH_DONE;
         end
      end
   end

   // counters and assembly
   always_comb begin
      byte_off_in  = byte_off_ff;
      hdr_end_in   = hdr_end_ff;
      len_asm_in   = len_asm_ff;
      len_idx_in   = len_idx_ff;
      entry_len_in = entry_len_ff;
      entry_pos_in = entry_pos_ff;
      alive_in     = alive_ff;
      if (step) begin
         byte_off_in = eff_off;
         len_asm_in  = eff_asm;
         len_idx_in  = eff_idx;
      end
      if (active) begin
         byte_off_in = next_off;
         unique case (eff_phase)
            chfs_pkg::PH_PREAMBLE: begin
               len_asm_in = pre_asm;
               if (pre_done) begin
                  hdr_end_in = hdr_end_new;
                  len_asm_in = '0;
                  len_idx_in = '0;
               end
            end
            chfs_pkg::PH_LENGTH: begin
               len_asm_in = len_asm;
               len_idx_in = eff_idx + 2'd1;
               if (len_done) begin
                  entry_len_in = len_value;
                  len_asm_in   = '0;
                  entry_pos_in = '0;
                  alive_in     = '1;
               end
            end
            chfs_pkg::PH_BODY: begin
               alive_in     = keep;
               entry_pos_in = pos_next;
               if (body_done) begin
                  len_asm_in = '0;
                  len_idx_in = '0;
               end
            end
            chfs_pkg::PH_DONE: begin
               byte_off_in = eff_off;
            end
            default: begin
               byte_off_in = eff_off;
            end
         endcase
      end
   end

   // results of this byte
   always_comb begin
      scan_out.field_valid = active && (eff_phase == chfs_pkg::PH_BODY) && hit_any;
      scan_out.end_valid   = end_hit;
      scan_out.field_rsp.event_kind   = chfs_pkg::EV_FIELD;
      scan_out.field_rsp.field_key    = hit_key;
      scan_out.field_rsp.value_offset = chfs_pkg::sat_out(next_off);
      scan_out.field_rsp.value_length = chfs_pkg::sat_out(hit_len);
      scan_out.field_rsp.last_of_run  = !end_hit;
      scan_out.end_rsp.event_kind     = chfs_pkg::EV_END;
      scan_out.end_rsp.field_key      = chfs_pkg::KEY_CALLERID;
      scan_out.end_rsp.value_offset   = '0;
      scan_out.end_rsp.value_length   = '0;
      scan_out.end_rsp.last_of_run    = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= chfs_pkg::PH_PREAMBLE;
         byte_off_ff  <= '0;
         hdr_end_ff   <= '0;
         len_asm_ff   <= '0;
         len_idx_ff   <= '0;
         entry_len_ff <= '0;
         entry_pos_ff <= '0;
         alive_ff     <= '1;
      end else begin
         phase_ff     <= phase_in;
         byte_off_ff  <= byte_off_in;
         hdr_end_ff   <= hdr_end_in;
         len_asm_ff   <= len_asm_in;
         len_idx_ff   <= len_idx_in;
         entry_len_ff <= entry_len_in;
         entry_pos_ff <= entry_pos_in;
         alive_ff     <= alive_in;
      end
   end

endmodule

// ----- sv/chfs_rsp_fifo.sv -----
module chfs_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  chfs_pkg::scan_out_type scan_out,
   output logic                   room,
   chfs_rsp_if.source             rsp_chan
);

   chfs_pkg::rsp_type mem_ff [chfs_pkg::RSP_DEPTH];
   logic [chfs_pkg::RSP_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [chfs_pkg::RSP_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [chfs_pkg::RSP_CNT_BITS-1:0] count_ff, count_in;
   logic [chfs_pkg::RSP_PTR_BITS-1:0] end_ptr;
   logic [1:0]                        push_n;
   logic                              pop;
   chfs_pkg::rsp_type                 head;

   // two free slots cover the worst byte
   assign room    = count_ff <= chfs_pkg::RSP_CNT_BITS'(chfs_pkg::RSP_DEPTH - 2);
   assign pop     = rsp_chan.valid && rsp_chan.ready;
   assign push_n  = {1'b0, scan_out.field_valid} + {1'b0, scan_out.end_valid};
   assign end_ptr = wr_ptr_ff + chfs_pkg::RSP_PTR_BITS'(scan_out.field_valid);

   assign wr_ptr_in = wr_ptr_ff + chfs_pkg::RSP_PTR_BITS'(push_n);
   assign rd_ptr_in = rd_ptr_ff + chfs_pkg::RSP_PTR_BITS'(pop);
   assign count_in  = count_ff + chfs_pkg::RSP_CNT_BITS'(push_n)
                      - chfs_pkg::RSP_CNT_BITS'(pop);

   assign head = mem_ff[rd_ptr_ff];

   assign rsp_chan.valid        = count_ff != '0;
   assign rsp_chan.event_kind   = head.event_kind;
   assign rsp_chan.field_key    = head.field_key;
   assign rsp_chan.value_offset = head.value_offset;
   assign rsp_chan.value_length = head.value_length;
   assign rsp_chan.last_of_run  = head.last_of_run;

   always_ff @(posedge clock) begin
      if (scan_out.field_valid) begin
         mem_ff[wr_ptr_ff] <= scan_out.field_rsp;
      end
      if (scan_out.end_valid) begin
         mem_ff[end_ptr] <= scan_out.end_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/connection_header_field_scanner_unit.sv -----
// channel   dir  handshake      beat contents
// req_chan  in   valid/ready    data_byte, first_of_packet
// rsp_chan  out  valid/ready    event_kind, field_key, value_offset, value_length, last_of_run
//
// one header byte per cycle while the queue has room: a byte is taken into the input
// register and scanned against the header state; its results land in a four-beat result queue
// a byte that yields a field and the header end produces two rsp beats in a row
// the scan step waits only while fewer than two queue slots are free
// reset is synchronous and returns the scanner to the preamble with an empty queue
module connection_header_field_scanner_unit (
   input  logic       clock,
   input  logic       reset,
   chfs_req_if.sink   req_chan,
   chfs_rsp_if.source rsp_chan
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_first_ff, in_first_in;

   logic                   accept;
   logic                   step;
   logic                   room;
   chfs_pkg::scan_out_type scan_out;

   // scan the held byte once the queue can take both possible results
   assign step           = in_valid_ff && room;
   assign req_chan.ready = !in_valid_ff || step;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_first_in = in_first_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.data_byte;
         in_first_in = req_chan.first_of_packet;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_first_ff <= in_first_in;
   end

   // header state and key matching
   chfs_scan_core u_scan (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .data_byte       (in_byte_ff),
      .first_of_packet (in_first_ff),
      .scan_out        (scan_out)
   );

   // result queue, drives the rsp beats
   chfs_rsp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .scan_out (scan_out),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- sim/tb_connection_header_field_scanner_unit.sv -----
module tb_connection_header_field_scanner_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import chfs_pkg::*;

   // cycles without any beat on either channel before the run is abandoned
   localparam int STALL_LIMIT = 2000;
   // settle time after the last awaited beat, covers input register plus scan stage
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_REPORTS = 10;
   // bytes of random stimulus per idling phase
   localparam int PHASE_BYTES = 400;

   // shapes of one header entry body
   typedef enum int {
      ENT_FIELD,
      ENT_BARE_KEY,
      ENT_SHORT,
      ENT_NEAR,
      ENT_NOISE,
      ENT_EMPTY,
      ENT_HUGE
   } entry_form_type;

   logic clock = 1'b0;
   logic reset;

   chfs_req_if req_bus ();
   chfs_rsp_if rsp_bus ();

   connection_header_field_scanner_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // key text and the code reported for it, same order
   string   key_word [NUM_KEYS] = '{"callerid=", "md5sum=", "tcp_nodely=", "topic=", "type="};
   key_type key_code [NUM_KEYS] = '{KEY_CALLERID, KEY_MD5SUM, KEY_NO_DELAY, KEY_TOPIC,
                                    KEY_TYPE};

   // scanner state as the testbench tracks it
   logic [OFFSET_BITS-1:0] scan_offset;
   logic [OFFSET_BITS-1:0] end_offset;
   logic [OFFSET_BITS-1:0] body_length;
   logic [OFFSET_BITS-1:0] body_pos;
   phase_type              scan_phase;
   logic [LEN_BITS-1:0]    word_acc;
   logic [1:0]             word_idx;
   logic [NUM_KEYS-1:0]    keys_alive;

   // field and end beats still owed by the dut, oldest first
   rsp_type    awaited_beats [$];
   // header under construction
   logic [7:0] pkt_bytes [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int bytes_sent = 0;
   int stall_cycles = 0;

   rsp_type got_beat;
   rsp_type want_beat;

   // ---------------------------------------------------------------------------------------
   // header scan prediction
   // ---------------------------------------------------------------------------------------

   // length words wider than the offset counters pin at the top
   function automatic logic [OFFSET_BITS-1:0] clamp_offset(input logic [LEN_BITS-1:0] v);
      return ((v >> OFFSET_BITS) != 0) ? OFFSET_MAX : OFFSET_BITS'(v);
   endfunction

   function automatic logic [OUT_BITS-1:0] clamp_field(input logic [LEN_BITS-1:0] v);
      return ((v >> OUT_BITS) != 0) ? OUT_MAX : OUT_BITS'(v);
   endfunction

   function automatic void reset_scan_model();
      scan_offset = '0;
      end_offset  = '0;
      scan_phase  = PH_PREAMBLE;
      word_acc    = '0;
      word_idx    = '0;
      body_length = '0;
      body_pos    = '0;
      keys_alive  = '1;
   endfunction

   // advance the tracked scanner by one accepted byte and queue the beats it owes
   function automatic void scan_header_byte(input logic [7:0] b, input logic mark);
      rsp_type                run_beats [$];
      rsp_type                beat;
      logic [OFFSET_BITS-1:0] next_off;
      logic [OFFSET_BITS-1:0] pos;
      logic                   at_boundary;
      int                     klen;
      at_boundary = 1'b0;
      // a packet mark restarts the scan at offset 0, whatever came before
      if (mark) begin
         scan_offset = '0;
         scan_phase  = PH_PREAMBLE;
         word_acc    = '0;
         word_idx    = '0;
      end
      // once the header end is seen the scanner sleeps until the next mark
      if (scan_phase != PH_DONE) begin
         next_off = (scan_offset == OFFSET_MAX) ? OFFSET_MAX : scan_offset + 1'b1;
         case (scan_phase)
            PH_PREAMBLE: begin
               // bytes 4..7 hold the header end offset, low byte first
               if (scan_offset >= 4 && scan_offset < 8) begin
                  word_acc = word_acc | (LEN_BITS'(b) << (8 * (int'(scan_offset) - 4)));
               end
               if (scan_offset >= 7) begin
                  end_offset  = clamp_offset(word_acc);
                  word_acc    = '0;
                  word_idx    = '0;
                  scan_phase  = PH_LENGTH;
                  at_boundary = 1'b1;
               end
            end
            PH_LENGTH: begin
               word_acc = word_acc | (LEN_BITS'(b) << (8 * int'(word_idx)));
               word_idx = word_idx + 1'b1;
               if (word_idx == 2'd0) begin
                  body_length = clamp_offset(word_acc);
                  word_acc    = '0;
                  body_pos    = '0;
                  keys_alive  = '1;
                  at_boundary = 1'b1;
                  // an empty entry goes straight on to the next length word
                  if (body_length != 0) begin
                     scan_phase = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               pos = body_pos;
               for (int k = 0; k < NUM_KEYS; k++) begin
                  klen = key_word[k].len();
                  if (keys_alive[k]) begin
                     if (int'(pos) >= klen || key_word[k][int'(pos)] != b) begin
                        keys_alive[k] = 1'b0;
                     end else if (int'(pos) == klen - 1) begin
                        // last key byte: value starts at the next offset
                        beat              = '0;
                        beat.event_kind   = EV_FIELD;
                        beat.field_key    = key_code[k];
                        beat.value_offset = clamp_field(LEN_BITS'(next_off));
                        beat.value_length = clamp_field(LEN_BITS'(body_length) -
                                                        LEN_BITS'(klen));
                        run_beats.push_back(beat);
                     end
                  end
               end
               body_pos = pos + 1'b1;
               if (body_pos >= body_length) begin
                  scan_phase  = PH_LENGTH;
                  word_acc    = '0;
                  word_idx    = '0;
                  at_boundary = 1'b1;
               end
            end
            default: begin
            end
         endcase
         // the header closes only on an entry boundary
         if (at_boundary && next_off >= end_offset) begin
            beat            = '0;
            beat.event_kind = EV_END;
            run_beats.push_back(beat);
            scan_phase = PH_DONE;
         end
         scan_offset = next_off;
         if (run_beats.size() != 0) begin
            run_beats[run_beats.size() - 1].last_of_run = 1'b1;
         end
         foreach (run_beats[i]) begin
            awaited_beats.push_back(run_beats[i]);
         end
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // header construction
   // ---------------------------------------------------------------------------------------

   function automatic void add_word(input logic [LEN_BITS-1:0] w);
      for (int i = 0; i < 4; i++) begin
         pkt_bytes.push_back(w[8*i +: 8]);
      end
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         pkt_bytes.push_back(s[i]);
      end
   endfunction

   function automatic void add_text_entry(input string s);
      add_word(s.len());
      add_text(s);
   endfunction

   // four skipped bytes, then room for the end offset word
   function automatic void begin_header();
      pkt_bytes.delete();
      repeat (4) pkt_bytes.push_back(8'($urandom));
      repeat (4) pkt_bytes.push_back(8'h00);
   endfunction

   function automatic void set_end_word(input logic [LEN_BITS-1:0] w);
      for (int i = 0; i < 4; i++) begin
         pkt_bytes[4 + i] = w[8*i +: 8];
      end
   endfunction

   function automatic void add_entry(input entry_form_type form);
      logic [7:0]          body [$];
      logic [LEN_BITS-1:0] len_word;
      int                  k;
      int                  klen;
      int                  cut;
      k    = $urandom_range(NUM_KEYS - 1);
      klen = key_word[k].len();
      case (form)
         ENT_FIELD, ENT_BARE_KEY, ENT_NEAR, ENT_HUGE: begin
            for (int j = 0; j < klen; j++) body.push_back(key_word[k][j]);
         end
         ENT_SHORT: begin
            // body ends before the key does
            cut = $urandom_range(1, klen - 1);
            for (int j = 0; j < cut; j++) body.push_back(key_word[k][j]);
         end
         ENT_NOISE: begin
            repeat ($urandom_range(1, 8)) body.push_back(8'($urandom));
         end
         default: begin
         end
      endcase
      // one flipped bit anywhere in the key, '=' included
      if (form == ENT_NEAR) begin
         cut       = $urandom_range(klen - 1);
         body[cut] = body[cut] ^ (8'h01 << $urandom_range(7));
      end
      if (form == ENT_FIELD || form == ENT_NEAR || form == ENT_HUGE) begin
         repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
      end
      len_word = body.size();
      // oversized length word, the body is never finished
      if (form == ENT_HUGE) begin
         len_word = {16'($urandom_range(1, 65535)), 16'($urandom)};
      end
      add_word(len_word);
      foreach (body[i]) pkt_bytes.push_back(body[i]);
   endfunction

   function automatic void build_random_header();
      int                  total;
      int                  pick;
      logic [LEN_BITS-1:0] end_word;
      entry_form_type      form;
      begin_header();
      repeat ($urandom_range(0, 5)) begin
         form = ($urandom_range(1) == 0) ? ENT_FIELD
                                          : entry_form_type'($urandom_range(ENT_EMPTY));
         add_entry(form);
      end
      total = pkt_bytes.size();
      if ($urandom_range(9) == 0) begin
         add_entry(ENT_HUGE);
      end
      // mostly an exact end; also early, late, saturated and inside the preamble
      pick = $urandom_range(99);
      if (pick < 55) begin
         end_word = total;
      end else if (pick < 70) begin
         end_word = $urandom_range(total);
      end else if (pick < 80) begin
         end_word = total + $urandom_range(1, 20);
      end else if (pick < 90) begin
         end_word = $urandom | 32'h0001_0000;
      end else begin
         end_word = $urandom_range(8);
      end
      set_end_word(end_word);
   endfunction

   // ---------------------------------------------------------------------------------------
   // channel drivers
   // ---------------------------------------------------------------------------------------

   // one req beat; valid only drops when the sender idles
   task automatic send_byte(input logic [7:0] b, input logic mark);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.data_byte       <= b;
      req_bus.first_of_packet <= mark;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      scan_header_byte(b, mark);
      bytes_sent++;
   endtask

   // first byte carries the given mark, the rest none
   task automatic send_packet(input logic mark, input int count);
      for (int i = 0; i < count; i++) begin
         send_byte(pkt_bytes[i], (i == 0) ? mark : 1'b0);
      end
   endtask

   // sender goes quiet until every owed beat has come back
   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (awaited_beats.size() != 0) @(posedge clock);
   endtask

   // receiver stalls at the current rate
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------------------------

   function automatic string beat_text(input rsp_type t);
      return $sformatf("kind=%0d key=%0d off=%0d len=%0d last=%0d", t.event_kind,
                       t.field_key, t.value_offset, t.value_length, t.last_of_run);
   endfunction

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t: %s", $time, msg);
      end
   endfunction

   // every rsp beat against the oldest owed beat
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
         got_beat.event_kind   = rsp_bus.event_kind;
         got_beat.field_key    = rsp_bus.field_key;
         got_beat.value_offset = rsp_bus.value_offset;
         got_beat.value_length = rsp_bus.value_length;
         got_beat.last_of_run  = rsp_bus.last_of_run;
         if (awaited_beats.size() == 0) begin
            note_error({"unexpected beat ", beat_text(got_beat)});
         end else begin
            want_beat = awaited_beats.pop_front();
            if (got_beat.event_kind !== want_beat.event_kind ||
                got_beat.field_key !== want_beat.field_key ||
                got_beat.value_offset !== want_beat.value_offset ||
                got_beat.value_length !== want_beat.value_length ||
                got_beat.last_of_run !== want_beat.last_of_run) begin
               note_error({"beat mismatch, want ", beat_text(want_beat), " got ",
                           beat_text(got_beat)});
            end
         end
      end
   end

   // no beat on either side for too long means the dut is stuck
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // right after reset, no packet mark: first byte is offset 0
   // all five keys, values with the byte extremes, then bytes dropped after the end
   task automatic test_every_key_without_mark();
      begin_header();
      for (int k = 0; k < NUM_KEYS; k++) begin
         add_word(key_word[k].len() + 2);
         add_text(key_word[k]);
         pkt_bytes.push_back(8'h00);
         pkt_bytes.push_back(8'hFF);
      end
      set_end_word(pkt_bytes.size());
      send_packet(1'b0, pkt_bytes.size());
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
   endtask

   // empty entry, bodies too short for a key, a near miss, and a final entry that
   // is just a key so its last byte yields both the field and the end
   task automatic test_short_and_empty_entries();
      begin_header();
      add_word(0);
      add_text_entry("topi");
      add_text_entry("typo=x");
      add_text_entry("tcp_nodely");
      add_text_entry("md5sum=");
      set_end_word(pkt_bytes.size());
      send_packet(1'b1, pkt_bytes.size());
   endtask

   // end offset already passed after an entry's length bytes, then one inside the preamble
   task automatic test_early_header_end();
      begin_header();
      add_text_entry("type=ab");
      set_end_word(10);
      send_packet(1'b1, pkt_bytes.size());
      begin_header();
      add_text_entry("callerid=x");
      set_end_word(0);
      send_packet(1'b1, pkt_bytes.size());
   endtask

   // end offset and entry length words beyond the counter range
   task automatic test_oversized_words();
      begin_header();
      add_word(32'hFFFF_FFFF);
      add_text("callerid=zz");
      set_end_word(32'hFFFF_FFFF);
      send_packet(1'b1, pkt_bytes.size());
      // restart in the middle of that open body
      begin_header();
      add_word(32'h0001_0000);
      add_text("topic=");
      set_end_word(32'h8000_0000);
      send_packet(1'b1, pkt_bytes.size());
   endtask

   // mostly well-formed headers with random entries, some cut short, some plain noise
   task automatic test_random_headers(input int item_budget);
      int stop_at;
      int pick;
      stop_at = bytes_sent + item_budget;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         build_random_header();
         if (pick < 80) begin
            send_packet(1'b1, pkt_bytes.size());
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
         end else if (pick < 90) begin
            send_packet(1'b1, $urandom_range(1, pkt_bytes.size()));
         end else begin
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom), $urandom_range(9) == 0);
         end
         if ($urandom_range(99) < 4) begin
            hold_until_drained();
         end
      end
   endtask

   initial begin
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.data_byte       = 8'h00;
      req_bus.first_of_packet = 1'b0;
      rsp_bus.ready           = 1'b0;
      reset_scan_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      send_idle_pct = 27;
      recv_idle_pct = 61;
      test_every_key_without_mark();
      test_short_and_empty_entries();
      test_early_header_end();
      test_oversized_words();
      test_random_headers(PHASE_BYTES);
      hold_until_drained();

      // roles swapped
      send_idle_pct = 61;
      recv_idle_pct = 27;
      test_random_headers(PHASE_BYTES);
      hold_until_drained();

      // full rate both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_headers(PHASE_BYTES);

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && awaited_beats.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
